/* src/awsp_pkg.sv */
// ----------------------------------------------------------------------------
// awsp_pkg
// Shared types and constants for the attention-weighted spatial pooling unit.
// ----------------------------------------------------------------------------
package awsp_pkg;

    // parameter defaults
    localparam int SPATIAL_MAX_DEF = 1024;
    localparam int CHANNEL_MAX_DEF = 4096;
    localparam int ACC_WIDTH_DEF   = 48;

    // fixed field widths
    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 16;
    localparam int CH_IDX_W    = 12;
    localparam int SP_CFG_W    = 11;
    localparam int CH_CFG_W    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    // position field sized for the largest supported SPATIAL_MAX
    localparam int POS_FIELD_W = 16;

    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [SP_CFG_W-1:0] SPATIAL_SIZE_RST  = 11'd64;
    localparam logic [CH_CFG_W-1:0] CHANNEL_COUNT_RST = 13'd64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SPATIAL_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_WEIGHT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SCALE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FEATURE = 2'd2;

    // output saturation limits, Q4.12
    localparam logic [VALUE_W-1:0] POOL_MAX = 16'h7FFF;
    localparam logic [VALUE_W-1:0] POOL_MIN = 16'h8000;

    typedef enum logic [1:0] {
        CMD_WEIGHT,
        CMD_SCALE,
        CMD_FEATURE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [VALUE_W-1:0]       value;
        logic [POS_FIELD_W-1:0]   pos;        // weight address or position
        logic                     chan_end;   // last position of the channel
        logic [CH_IDX_W-1:0]      chan_idx;
        logic                     chan_last;  // last channel of the sample
    } cmd_t;

    typedef struct packed {
        logic [SP_CFG_W-1:0] spatial_size;
        logic [CH_CFG_W-1:0] channel_count;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_ABS,
        B_SCL_LO,
        B_SCL_HI,
        B_SUM,
        B_OUT
    } back_state_t;

endpackage

/* src/attention_weighted_spatial_pool_unit.sv */
// ----------------------------------------------------------------------------
// attention_weighted_spatial_pool_unit
// Soft-attention weighted-sum pooling: per-position weights times features,
// summed per channel, scaled per sample, saturated Q4.12 output.
// ----------------------------------------------------------------------------
// Path: a channel-ending feature passes the queue, weight read, multiply,
//   accumulate, 4 scale steps and the output register, which waits while a
//   held result is not yet taken. A 4-entry queue absorbs bursts at 1 per
//   cycle until full; back end takes one weight or scale request per cycle
//   while idle; a feature holds it through MAC, and scale/output at channel end.
// Reset: aresetn synchronous, active low; clears counters, scale, accumulator,
//   queue and output valid. Weight store is not cleared (undefined until loaded).
module attention_weighted_spatial_pool_unit
    import awsp_pkg::*;
#(
    parameter int SPATIAL_MAX = SPATIAL_MAX_DEF,
    parameter int CHANNEL_MAX = CHANNEL_MAX_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [15:0] value
    input  logic [ACTION_W-1:0]    s_tuser,   // [1:0] action
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [15:0] pooled, [27:16] channel_index
    output logic                   m_tlast,   // last channel of the sample
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_regs_t           cfg_reg;
    logic                q_push, q_full, q_pop, q_empty;
    cmd_t                q_data, q_head;
    logic [VALUE_W-1:0]  pooled;
    logic [CH_IDX_W-1:0] chan_idx;

    // configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spatial_size  <= SPATIAL_SIZE_RST;
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SPATIAL_SIZE:  cfg_reg.spatial_size  <= cfg_wdata[SP_CFG_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_wdata[CH_CFG_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // front end: classify requests, advance pointers and counters
    awsp_front #(
        .SPATIAL_MAX (SPATIAL_MAX),
        .CHANNEL_MAX (CHANNEL_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_action (s_tuser),
        .s_value  (s_tdata),
        .cfg      (cfg_reg),
        .q_push   (q_push),
        .q_data   (q_data),
        .q_full   (q_full)
    );

    // decouples request intake from the multi-cycle back end
    awsp_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // back end: weight store, MAC, scale/round/saturate, output register
    awsp_back #(
        .SPATIAL_MAX (SPATIAL_MAX),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_pooled   (pooled),
        .m_chan_idx (chan_idx),
        .m_last     (m_tlast)
    );

    assign m_tdata = {4'b0000, chan_idx, pooled};

endmodule

/* src/awsp_front.sv */
// ----------------------------------------------------------------------------
// awsp_front
// Accepts input items, tracks weight pointer, position and channel counters,
// and turns each item into a command for the back end.
// ----------------------------------------------------------------------------
module awsp_front
    import awsp_pkg::*;
#(
    parameter int SPATIAL_MAX = SPATIAL_MAX_DEF,
    parameter int CHANNEL_MAX = CHANNEL_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [VALUE_W-1:0]  s_value,
    input  cfg_regs_t           cfg,
    output logic                q_push,
    output cmd_t                q_data,
    input  logic                q_full
);

    localparam int PW  = (SPATIAL_MAX > 1) ? $clog2(SPATIAL_MAX) : 1;
    localparam int CW  = (CHANNEL_MAX > 1) ? $clog2(CHANNEL_MAX) : 1;
    localparam int SPW = ($clog2(SPATIAL_MAX + 1) > SP_CFG_W) ?
                         $clog2(SPATIAL_MAX + 1) : SP_CFG_W;
    localparam int NCW = ($clog2(CHANNEL_MAX + 1) > CH_CFG_W) ?
                         $clog2(CHANNEL_MAX + 1) : CH_CFG_W;

    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  pos_reg,  pos_next;
    logic [CW-1:0]  ch_reg,   ch_next;
    logic [SPW-1:0] sp_eff;
    logic [NCW-1:0] nch_eff;
    logic           accept;
    logic           wptr_wrap, pos_wrap, ch_last;

    // clamp register values to the supported range
    always_comb begin
        if (cfg.spatial_size == '0) begin
            sp_eff = SPW'(1);
        end else if (SPW'(cfg.spatial_size) > SPW'(SPATIAL_MAX)) begin
            sp_eff = SPW'(SPATIAL_MAX);
        end else begin
            sp_eff = SPW'(cfg.spatial_size);
        end
        if (cfg.channel_count == '0) begin
            nch_eff = NCW'(1);
        end else if (NCW'(cfg.channel_count) > NCW'(CHANNEL_MAX)) begin
            nch_eff = NCW'(CHANNEL_MAX);
        end else begin
            nch_eff = NCW'(cfg.channel_count);
        end
    end

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign wptr_wrap = (SPW'(wptr_reg) + SPW'(1)) >= sp_eff;
    assign pos_wrap  = (SPW'(pos_reg) + SPW'(1)) >= sp_eff;
    assign ch_last   = (NCW'(ch_reg) + NCW'(1)) >= nch_eff;

    always_comb begin
        q_push         = 1'b0;
        q_data.kind    = CMD_SCALE;
        q_data.value   = s_value;
        q_data.pos     = POS_FIELD_W'(pos_reg);
        q_data.chan_end  = 1'b0;
        q_data.chan_idx  = CH_IDX_W'(ch_reg);
        q_data.chan_last = ch_last;
        wptr_next      = wptr_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        case (s_action)
            ACT_WEIGHT: begin
                q_push      = accept;
                q_data.kind = CMD_WEIGHT;
                q_data.pos  = POS_FIELD_W'(wptr_reg);
                if (accept) begin
                    wptr_next = wptr_wrap ? '0 : wptr_reg + PW'(1);
                end
            end
            ACT_SCALE: begin
                q_push      = accept;
                q_data.kind = CMD_SCALE;
            end
            ACT_FEATURE: begin
                q_push          = accept;
                q_data.kind     = CMD_FEATURE;
                q_data.chan_end = pos_wrap;
                if (accept) begin
                    pos_next = pos_wrap ? '0 : pos_reg + PW'(1);
                    if (pos_wrap) begin
                        ch_next = ch_last ? '0 : ch_reg + CW'(1);
                    end
                end
            end
            default: begin
                // reserved action: consumed, no command
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            pos_reg  <= '0;
            ch_reg   <= '0;
        end else begin
            wptr_reg <= wptr_next;
            pos_reg  <= pos_next;
            ch_reg   <= ch_next;
        end
    end

endmodule

/* src/awsp_cmd_queue.sv */
// ----------------------------------------------------------------------------
// awsp_cmd_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module awsp_cmd_queue
    import awsp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/awsp_back.sv */
// ----------------------------------------------------------------------------
// awsp_back
// Executes commands: weight store, scale, multiply-accumulate, and the
// end-of-channel scale, round and saturate into the output register.
// ----------------------------------------------------------------------------
module awsp_back
    import awsp_pkg::*;
#(
    parameter int SPATIAL_MAX = SPATIAL_MAX_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  cmd_t                q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_pooled,
    output logic [CH_IDX_W-1:0] m_chan_idx,
    output logic                m_last
);

    localparam int PW     = (SPATIAL_MAX > 1) ? $clog2(SPATIAL_MAX) : 1;
    localparam int MAG_W  = 64;
    localparam int HALF_W = 32;
    localparam int PP_W   = HALF_W + VALUE_W;      // partial product
    localparam int SUM_W  = PP_W + HALF_W;
    localparam int FRAC_SH = 24;                   // Q12.36 -> Q4.12
    localparam int Q_W    = SUM_W - FRAC_SH;

    back_state_t state_reg, state_next;

    logic [VALUE_W-1:0]         weight_mem [SPATIAL_MAX];
    logic signed [VALUE_W-1:0]  w_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    logic signed [2*VALUE_W-1:0] prod_reg;
    logic [ACC_WIDTH-1:0]       acc_reg;
    logic [VALUE_W-1:0]         scale_reg;
    logic                       end_reg, last_reg;
    logic [CH_IDX_W-1:0]        ch_reg;
    logic                       neg_reg;
    logic [MAG_W-1:0]           amag_reg;
    logic [VALUE_W-1:0]         smag_reg;
    logic [PP_W-1:0]            plo_reg, phi_reg;
    logic [Q_W-1:0]             q_reg;
    logic                       out_valid_reg;
    logic [VALUE_W-1:0]         out_pooled_reg;
    logic [CH_IDX_W-1:0]        out_ch_reg;
    logic                       out_last_reg;

    logic                       load_out;
    logic [VALUE_W-1:0]         sat_val;
    logic signed [MAG_W-1:0]    acc_ext;
    logic [SUM_W-1:0]           sum;
    logic [PW-1:0]              head_addr;

    assign head_addr = q_head.pos[PW-1:0];
    assign acc_ext   = MAG_W'(signed'(acc_reg));
    assign sum       = {phi_reg, HALF_W'(0)} + SUM_W'(plo_reg) + (SUM_W'(1) << (FRAC_SH - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty && q_head.kind == CMD_FEATURE) begin
                    state_next = B_MUL;
                end
            end
            B_MUL:    state_next = B_ACC;
            B_ACC:    state_next = end_reg ? B_ABS : B_IDLE;
            B_ABS:    state_next = B_SCL_LO;
            B_SCL_LO: state_next = B_SCL_HI;
            B_SCL_HI: state_next = B_SUM;
            B_SUM:    state_next = B_OUT;
            B_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:  q_pop    = !q_empty;
            B_OUT:   load_out = !out_valid_reg || m_ready;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // round-half-away result magnitude -> saturated Q4.12
    always_comb begin
        if (neg_reg) begin
            if (q_reg >= Q_W'(32768)) begin
                sat_val = POOL_MIN;
            end else begin
                sat_val = ~q_reg[VALUE_W-1:0] + VALUE_W'(1);
            end
        end else begin
            if (q_reg > Q_W'(32767)) begin
                sat_val = POOL_MAX;
            end else begin
                sat_val = q_reg[VALUE_W-1:0];
            end
        end
    end

    // weight store
    always_ff @(posedge aclk) begin
        if (q_pop && q_head.kind == CMD_WEIGHT) begin
            weight_mem[head_addr] <= q_head.value;
        end
        if (q_pop && q_head.kind == CMD_FEATURE) begin
            w_reg <= weight_mem[head_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            acc_reg       <= '0;
            scale_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop && q_head.kind == CMD_SCALE) begin
                scale_reg <= q_head.value;
            end
            if (state_reg == B_ACC) begin
                acc_reg <= acc_reg + ACC_WIDTH'(prod_reg);
            end else if (state_reg == B_ABS) begin
                acc_reg <= '0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            val_reg  <= q_head.value;
            end_reg  <= q_head.chan_end;
            ch_reg   <= q_head.chan_idx;
            last_reg <= q_head.chan_last;
        end
        if (state_reg == B_MUL) begin
            prod_reg <= w_reg * val_reg;
        end
        if (state_reg == B_ABS) begin
            neg_reg  <= acc_reg[ACC_WIDTH-1] ^ scale_reg[VALUE_W-1];
            amag_reg <= acc_reg[ACC_WIDTH-1] ? MAG_W'(-acc_ext) : MAG_W'(acc_ext);
            smag_reg <= scale_reg[VALUE_W-1] ? (~scale_reg + VALUE_W'(1)) : scale_reg;
        end
        if (state_reg == B_SCL_LO) begin
            plo_reg <= amag_reg[HALF_W-1:0] * smag_reg;
        end
        if (state_reg == B_SCL_HI) begin
            phi_reg <= amag_reg[MAG_W-1:HALF_W] * smag_reg;
        end
        if (state_reg == B_SUM) begin
            q_reg <= sum[SUM_W-1:FRAC_SH];
        end
        if (load_out) begin
            out_pooled_reg <= sat_val;
            out_ch_reg     <= ch_reg;
            out_last_reg   <= last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_pooled   = out_pooled_reg;
    assign m_chan_idx = out_ch_reg;
    assign m_last     = out_last_reg;

    // commands leave the queue only while the sequencer is idle
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == B_IDLE))
        else $error("command popped outside idle");

    // a result appears only from the output step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == B_OUT))
        else $error("result raised outside output step");

    // output step with a free register always delivers
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_OUT && !out_valid_reg) |=> out_valid_reg)
        else $error("output step did not load result");

    // accumulator is cleared once a channel result is being formed
    a_acc_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SCL_LO) |-> (acc_reg == '0))
        else $error("accumulator not cleared at channel end");

endmodule
